[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define BDP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[src/bdp_pkg.sv]
package bdp_pkg;

    // Default field width and the largest count that gets an exact search.
    localparam int DEF_WIDTH       = 16;
    localparam int DEF_EXACT_LIMIT = 256;

    // Small odd divisors preferred by the estimate.
    localparam int FACTOR_FIVE  = 5;
    localparam int FACTOR_THREE = 3;

endpackage

[src/bdp_if.sv]
// Request channel: a count and a limit.
interface bdp_in_if #(
    parameter int WIDTH = bdp_pkg::DEF_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] total_count;
    logic [WIDTH-1:0] max_factor;

    modport source (output valid, output total_count, output max_factor, input ready);
    modport sink   (input valid, input total_count, input max_factor, output ready);
endinterface

// Result channel: the chosen divisor and the zero-limit flag.
interface bdp_out_if #(
    parameter int WIDTH = bdp_pkg::DEF_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] chosen_factor;
    logic             bad_limit;

    modport source (output valid, output chosen_factor, output bad_limit, input ready);
    modport sink   (input valid, input chosen_factor, input bad_limit, output ready);
endinterface

[src/bounded_divisor_pick_top.sv]
// Bounded divisor pick. Each request carries a count and a limit; the block returns one
// divisor of the count that does not exceed the limit. When the limit is at least the count,
// the count itself comes back. Counts up to EXACT_LIMIT get the largest divisor at or below
// the limit, found by trying candidates downward from the limit. Larger counts get the limit
// when it divides the count, and otherwise an estimate: the smaller of the count's lowest set
// bit and the largest power of two not above the limit, replaced by 5 or else 3 when that
// value divides the count, is below the limit and is above the estimate. A zero limit returns
// 0 with bad_limit set. All remainders come from one restoring remainder unit that retires one
// dividend bit per cycle. Trivial cases go straight to the state that hands the result to the
// output register. An exact search tries candidates from the limit down to the divisor found,
// or down to 2 (a count with no divisor above one stops after candidate 2), shifting EXB bits
// into the remainder per candidate, the bit count of EXACT_LIMIT (9 for the default). A large
// count needs only the remainder by the limit when the limit divides it, and otherwise also the
// power-of-two scan and the remainders by 5 and by 3 as needed. The block takes one request at
// a time; a finished result waits in the output register, and the next request may be accepted
// meanwhile. No state survives a request, and there is no clearing pass after reset.
module bounded_divisor_pick_top
    import bdp_pkg::*;
#(
    parameter int WIDTH       = DEF_WIDTH,
    parameter int EXACT_LIMIT = DEF_EXACT_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdp_in_if.sink    i_req,
    bdp_out_if.source o_rsp
);

    // The exact-search bound, clipped to what a WIDTH-bit count can reach.
    localparam longint unsigned FULL  = (64'd1 << WIDTH) - 64'd1;
    localparam longint unsigned LIMC  = (EXACT_LIMIT < FULL) ? EXACT_LIMIT : FULL;
    // Exact-path counts fit in EXB bits, so the remainder unit only needs EXB steps there.
    localparam int              EXB   = $clog2(LIMC + 64'd1);
    localparam int              CW    = $clog2(WIDTH + 1);

    localparam logic [WIDTH-1:0] LIM_W   = WIDTH'(LIMC);
    localparam logic [WIDTH-1:0] FIVE_W  = WIDTH'(FACTOR_FIVE);
    localparam logic [WIDTH-1:0] THREE_W = WIDTH'(FACTOR_THREE);
    localparam logic [WIDTH-1:0] ONE_W   = WIDTH'(1);
    localparam logic [WIDTH-1:0] TWO_W   = WIDTH'(2);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] S_EXACT = 3'd1;  // descending candidate search
    localparam logic [2:0] S_DIVD  = 3'd2;  // count modulo limit
    localparam logic [2:0] S_POW   = 3'd3;  // power-of-two scan of the limit
    localparam logic [2:0] S_DIV5  = 3'd4;  // count modulo five
    localparam logic [2:0] S_DIV3  = 3'd5;  // count modulo three
    localparam logic [2:0] S_FIN   = 3'd6;  // hand the result to the output register

    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_n, n_n;          // count
    logic [WIDTH-1:0] r_d, n_d;          // limit
    logic [WIDTH-1:0] r_c, n_c;          // divisor under test
    logic [WIDTH-1:0] r_dvd, n_dvd;      // dividend bits still to shift in
    logic [WIDTH-1:0] r_rem, n_rem;      // partial remainder
    logic [CW-1:0]    r_cnt, n_cnt;      // remainder steps left
    logic [WIDTH-1:0] r_p, n_p;          // power-of-two scan value
    logic [WIDTH-1:0] r_p2, n_p2;        // power-of-two estimate
    logic [WIDTH-1:0] r_res, n_res;      // pending result
    logic             r_bad, n_bad;
    logic             r_ov, n_ov;        // output register holds a result
    logic [WIDTH-1:0] r_of, n_of;
    logic             r_ob, n_ob;

    // One restoring remainder step.
    logic [WIDTH:0]   trial;
    logic             fits;
    logic [WIDTH-1:0] step_rem;
    logic             last_step;
    logic             rem_zero;

    // Power-of-two estimate at the end of the scan.
    logic [WIDTH-1:0] low_bit;
    logic [WIDTH-1:0] est;
    logic             out_free;

    always_comb begin
        trial     = {r_rem, r_dvd[WIDTH-1]};
        fits      = trial >= {1'b0, r_c};
        step_rem  = fits ? WIDTH'(trial - {1'b0, r_c}) : trial[WIDTH-1:0];
        last_step = r_cnt == CW'(1);
        rem_zero  = step_rem == '0;
        low_bit   = r_n & (~r_n + ONE_W);
        est       = (low_bit < r_p) ? low_bit : r_p;
        out_free  = !r_ov || o_rsp.ready;
    end

    assign i_req.ready         = r_state == S_IDLE;
    assign o_rsp.valid         = r_ov;
    assign o_rsp.chosen_factor = r_of;
    assign o_rsp.bad_limit     = r_ob;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_c     = r_c;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_p2    = r_p2;
        n_res   = r_res;
        n_bad   = r_bad;
        n_of    = r_of;
        n_ob    = r_ob;
        n_ov    = r_ov && !o_rsp.ready;

        // Every divide state shifts one dividend bit into the remainder per cycle.
        if (r_state == S_EXACT || r_state == S_DIVD || r_state == S_DIV5 ||
            r_state == S_DIV3) begin
            n_rem = step_rem;
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_n   = i_req.total_count;
                    n_d   = i_req.max_factor;
                    n_bad = 1'b0;
                    n_rem = '0;
                    if (i_req.max_factor == '0) begin
                        n_res   = '0;
                        n_bad   = 1'b1;
                        n_state = S_FIN;
                    end else if (i_req.max_factor >= i_req.total_count) begin
                        n_res   = i_req.total_count;
                        n_state = S_FIN;
                    end else if (i_req.total_count <= LIM_W) begin
                        if (i_req.max_factor == ONE_W) begin
                            n_res   = ONE_W;
                            n_state = S_FIN;
                        end else begin
                            // Exact counts are left-aligned so only EXB steps are needed.
                            n_c     = i_req.max_factor;
                            n_dvd   = i_req.total_count << (WIDTH - EXB);
                            n_cnt   = CW'(EXB);
                            n_state = S_EXACT;
                        end
                    end else begin
                        n_c     = i_req.max_factor;
                        n_dvd   = i_req.total_count;
                        n_cnt   = CW'(WIDTH);
                        n_state = S_DIVD;
                    end
                end
            end
            S_EXACT: begin
                if (last_step) begin
                    if (rem_zero) begin
                        n_res   = r_c;
                        n_state = S_FIN;
                    end else if (r_c == TWO_W) begin
                        // No candidate above one divides the count.
                        n_res   = ONE_W;
                        n_state = S_FIN;
                    end else begin
                        n_c   = r_c - ONE_W;
                        n_rem = '0;
                        n_dvd = r_n << (WIDTH - EXB);
                        n_cnt = CW'(EXB);
                    end
                end
            end
            S_DIVD: begin
                if (last_step) begin
                    if (rem_zero) begin
                        n_res   = r_d;
                        n_state = S_FIN;
                    end else begin
                        n_p     = ONE_W;
                        n_state = S_POW;
                    end
                end
            end
            S_POW: begin
                if (r_p <= (r_d >> 1)) begin
                    n_p = r_p << 1;
                end else begin
                    n_p2  = est;
                    n_rem = '0;
                    n_dvd = r_n;
                    n_cnt = CW'(WIDTH);
                    if (FIVE_W < r_d && FIVE_W > est) begin
                        n_c     = FIVE_W;
                        n_state = S_DIV5;
                    end else if (THREE_W < r_d && THREE_W > est) begin
                        n_c     = THREE_W;
                        n_state = S_DIV3;
                    end else begin
                        n_res   = est;
                        n_state = S_FIN;
                    end
                end
            end
            S_DIV5: begin
                if (last_step) begin
                    if (rem_zero) begin
                        n_res   = FIVE_W;
                        n_state = S_FIN;
                    end else if (THREE_W < r_d && THREE_W > r_p2) begin
                        n_c     = THREE_W;
                        n_rem   = '0;
                        n_dvd   = r_n;
                        n_cnt   = CW'(WIDTH);
                        n_state = S_DIV3;
                    end else begin
                        n_res   = r_p2;
                        n_state = S_FIN;
                    end
                end
            end
            S_DIV3: begin
                if (last_step) begin
                    n_res   = rem_zero ? THREE_W : r_p2;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Wait here while an earlier result still sits unclaimed.
                if (out_free) begin
                    n_of    = r_res;
                    n_ob    = r_bad;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_d   <= n_d;
        r_c   <= n_c;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_p   <= n_p;
        r_p2  <= n_p2;
        r_res <= n_res;
        r_bad <= n_bad;
        r_of  <= n_of;
        r_ob  <= n_ob;
    end

endmodule

[src/bdp_checker.sv]
`include "assert_macros.svh"

module bdp_checker
    import bdp_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [WIDTH-1:0] i_out_factor,
    input logic             i_out_bad
);

    // A stalled result keeps its payload.
    `BDP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_factor) && $stable(i_out_bad))

    // The block works on one request at a time, so it is busy right after taking one.
    `BDP_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A zero limit always comes back with a zero factor.
    `BDP_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_out_bad, i_out_factor == '0)

endmodule

bind bounded_divisor_pick_top bdp_checker #(.WIDTH(WIDTH)) u_bdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_factor (o_rsp.chosen_factor),
    .i_out_bad    (o_rsp.bad_limit)
);
